[rtl/terminal_line_editor_top_defines.svh]
// Assertion macros used by the RTL controller of the terminal line editor.
`ifndef TERMINAL_LINE_EDITOR_TOP_DEFINES_SVH
`define TERMINAL_LINE_EDITOR_TOP_DEFINES_SVH

// Sampling clock and reset qualifier used by every concurrent check.
`define TLE_CLK_RST @(posedge clk_i) disable iff (!rst_ni)

// A labeled concurrent assertion that reports through $error.
`define TLE_ASSERT(label, prop, msg) \
  label: assert property (`TLE_CLK_RST prop) else $error(msg);

`endif

[rtl/tle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tle_pkg;

  localparam int unsigned LINE_LENGTH_DEFAULT = 64;

  localparam logic [7:0] KEY_EOF    = 8'd4;
  localparam logic [7:0] KEY_BS     = 8'd8;
  localparam logic [7:0] KEY_NL     = 8'd10;
  localparam logic [7:0] KEY_KILL   = 8'd21;
  localparam logic [7:0] KEY_WERASE = 8'd23;
  localparam logic [7:0] KEY_DEL    = 8'd127;
  localparam logic [7:0] KEY_SPACE  = 8'd32;
  localparam logic [7:0] KEY_TILDE  = 8'd126;

  typedef enum logic [2:0] {
    ACT_CHAR    = 3'd0,
    ACT_NEWLINE = 3'd1,
    ACT_ERASE   = 3'd2,
    ACT_KILL    = 3'd3,
    ACT_BEEP    = 3'd4,
    ACT_END     = 3'd5
  } echo_action_e;

  typedef enum logic [2:0] {
    KC_NL,
    KC_EOF,
    KC_KILL,
    KC_ERASE,
    KC_WERASE,
    KC_PRINT,
    KC_OTHER
  } key_class_e;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_CLEAR,
    CUR_INC,
    CUR_DEC
  } cur_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPACES,
    ST_WORD,
    ST_PUT
  } tle_state_e;

  typedef struct packed {
    logic         push;
    echo_action_e act;
    logic         last;
    logic         use_key_q;
    cur_op_e      cur_op;
    logic         wr_en;
    logic         load_key;
    logic         set_finished;
    logic         word_next;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       cur_zero;
    logic       cur_one;
    logic       cur_full;
    logic       rd_space;
    logic       out_free;
    logic       finished;
    key_class_e key_class;
  } ctrl_sts_t;

  function automatic key_class_e classify_key(input logic [7:0] key);
    key_class_e kc;
    if (key == KEY_NL) begin
      kc = KC_NL;
    end else if (key == KEY_EOF) begin
      kc = KC_EOF;
    end else if (key == KEY_KILL) begin
      kc = KC_KILL;
    end else if (key == KEY_BS || key == KEY_DEL) begin
      kc = KC_ERASE;
    end else if (key == KEY_WERASE) begin
      kc = KC_WERASE;
    end else if (key < KEY_SPACE || key > KEY_TILDE) begin
      kc = KC_OTHER;
    end else begin
      kc = KC_PRINT;
    end
    return kc;
  endfunction

endpackage
`default_nettype wire

[rtl/terminal_line_editor_top.sv]
// Channel   Direction  tdata (low bit up)                  tuser  tlast
// s_axis    in         key_byte[7:0]                       -      -
// m_axis    out        echo_action[2:0], echo_char[10:3]   -      last_of_run
//
// A key other than word erase that gives at most one result is taken, and its result registered, in the same cycle.
// A printable key on a full line gives two results: newline, then the character.
// Word erase steps through ST_SPACES and ST_WORD, one erased character per cycle while
// m_axis accepts results, reading the line store through its single read port.
// Reset needs no clearing pass; only line store data read below the cursor is used.
// A stalled m_axis holds the result and pauses the editor; s_axis waits meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module terminal_line_editor_top #(
  parameter int unsigned LINE_LENGTH = tle_pkg::LINE_LENGTH_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // key_byte[7:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // echo_action[2:0], echo_char[10:3], zero[15:11]
  output logic             m_axis_tlast
);
  import tle_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_sts_t  sts;
  logic [2:0] out_action;
  logic [7:0] out_char;

  tle_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tle_datapath #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_action_o(out_action),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, out_char, out_action};

endmodule
`default_nettype wire

[rtl/tle_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module tle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/tle_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module tle_datapath #(
  parameter int unsigned LINE_LENGTH = tle_pkg::LINE_LENGTH_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         key_i,
  input  wire tle_pkg::ctrl_cmd_t cmd_i,
  output tle_pkg::ctrl_sts_t      sts_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [2:0]              out_action_o,
  output logic [7:0]              out_char_o,
  output logic                    out_last_o
);
  import tle_pkg::*;

  localparam int unsigned STORE_DEPTH = LINE_LENGTH - 1;
  localparam int unsigned ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CUR_W = $clog2(LINE_LENGTH);

  logic [CUR_W-1:0] cursor_q, cursor_d;
  logic             finished_q, finished_d;
  logic [7:0]       key_q;
  logic [7:0]       sel_key;
  logic [CUR_W-1:0] rd_ptr;
  logic [7:0]       rdata;
  logic             out_valid_q;
  echo_action_e     act_q;
  logic [7:0]       char_q;
  logic             last_q;

  assign sel_key = cmd_i.use_key_q ? key_q : key_i;

  always_comb begin
    case (cmd_i.cur_op)
      CUR_CLEAR: cursor_d = '0;
      CUR_INC:   cursor_d = cursor_q + CUR_W'(1);
      CUR_DEC:   cursor_d = cursor_q - CUR_W'(1);
      default:   cursor_d = cursor_q;
    endcase
  end

  assign finished_d = finished_q | cmd_i.set_finished;
  assign rd_ptr = cursor_d - (cmd_i.word_next ? CUR_W'(2) : CUR_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q   <= cursor_d;
      finished_q <= finished_d;
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      key_q <= key_i;
    end
    if (cmd_i.push) begin
      act_q  <= cmd_i.act;
      char_q <= (cmd_i.act == ACT_CHAR) ? sel_key : 8'd0;
      last_q <= cmd_i.last;
    end
  end

  tle_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(cursor_q[ADDR_W-1:0]),
    .wdata_i(sel_key),
    .raddr_i(rd_ptr[ADDR_W-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    sts_o.cur_zero  = (cursor_q == '0);
    sts_o.cur_one   = (cursor_q == CUR_W'(1));
    sts_o.cur_full  = (cursor_q >= CUR_W'(LINE_LENGTH - 1));
    sts_o.rd_space  = (rdata == KEY_SPACE);
    sts_o.out_free  = !out_valid_q || out_ready_i;
    sts_o.finished  = finished_q;
    sts_o.key_class = classify_key(key_i);
  end

  assign out_valid_o  = out_valid_q;
  assign out_action_o = act_q;
  assign out_char_o   = char_q;
  assign out_last_o   = last_q;

endmodule
`default_nettype wire

[rtl/tle_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "terminal_line_editor_top_defines.svh"
module tle_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire tle_pkg::ctrl_sts_t sts_i,
  output tle_pkg::ctrl_cmd_t      cmd_o
);
  import tle_pkg::*;

  tle_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.act  = ACT_CHAR;
    cmd_o.cur_op = CUR_HOLD;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free && !sts_i.finished) begin
          case (sts_i.key_class)
            KC_NL: begin
              cmd_o.push   = 1'b1;
              cmd_o.act    = ACT_NEWLINE;
              cmd_o.last   = 1'b1;
              cmd_o.cur_op = CUR_CLEAR;
            end
            KC_EOF: begin
              if (sts_i.cur_zero) begin
                cmd_o.push         = 1'b1;
                cmd_o.act          = ACT_END;
                cmd_o.last         = 1'b1;
                cmd_o.set_finished = 1'b1;
              end
            end
            KC_KILL: begin
              cmd_o.push   = 1'b1;
              cmd_o.act    = ACT_KILL;
              cmd_o.last   = 1'b1;
              cmd_o.cur_op = CUR_CLEAR;
            end
            KC_ERASE: begin
              if (!sts_i.cur_zero) begin
                cmd_o.push   = 1'b1;
                cmd_o.act    = ACT_ERASE;
                cmd_o.last   = 1'b1;
                cmd_o.cur_op = CUR_DEC;
              end
            end
            KC_WERASE: begin
              state_d = ST_SPACES;
            end
            KC_PRINT: begin
              if (sts_i.cur_full) begin
                cmd_o.push     = 1'b1;
                cmd_o.act      = ACT_NEWLINE;
                cmd_o.cur_op   = CUR_CLEAR;
                cmd_o.load_key = 1'b1;
                state_d        = ST_PUT;
              end else begin
                cmd_o.push   = 1'b1;
                cmd_o.act    = ACT_CHAR;
                cmd_o.last   = 1'b1;
                cmd_o.wr_en  = 1'b1;
                cmd_o.cur_op = CUR_INC;
              end
            end
            default: begin
              cmd_o.push = 1'b1;
              cmd_o.act  = ACT_BEEP;
              cmd_o.last = 1'b1;
            end
          endcase
        end
      end
      ST_SPACES: begin
        if (sts_i.cur_zero) begin
          state_d = ST_IDLE;
        end else if (sts_i.rd_space) begin
          if (sts_i.out_free) begin
            cmd_o.push   = 1'b1;
            cmd_o.act    = ACT_ERASE;
            cmd_o.last   = sts_i.cur_one;
            cmd_o.cur_op = CUR_DEC;
            if (sts_i.cur_one) begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          state_d = ST_WORD;
        end
      end
      ST_WORD: begin
        if (sts_i.out_free) begin
          cmd_o.push   = 1'b1;
          cmd_o.act    = ACT_ERASE;
          cmd_o.last   = sts_i.cur_one || sts_i.rd_space;
          cmd_o.cur_op = CUR_DEC;
          if (sts_i.cur_one || sts_i.rd_space) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PUT: begin
        if (sts_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.act       = ACT_CHAR;
          cmd_o.last      = 1'b1;
          cmd_o.use_key_q = 1'b1;
          cmd_o.wr_en     = 1'b1;
          cmd_o.cur_op    = CUR_INC;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // While erasing a word, the store read runs one character ahead of the cursor.
    cmd_o.word_next = (state_d == ST_WORD);
  end

  `TLE_ASSERT(a_word_not_empty, (state_q == ST_WORD) |-> !sts_i.cur_zero, "word erase on empty line")
  `TLE_ASSERT(a_push_when_free, cmd_o.push |-> sts_i.out_free, "result pushed into full output")
  `TLE_ASSERT(a_put_at_start, (state_q == ST_PUT) |-> sts_i.cur_zero, "wrapped char not at line start")
  `TLE_ASSERT(a_quiet_after_end, sts_i.finished |-> !cmd_o.push || (state_q != ST_IDLE), "result after end")
  `TLE_ASSERT(a_end_sets_finished, (cmd_o.push && cmd_o.act == ACT_END) |=> sts_i.finished, "end did not stick")

endmodule
`default_nettype wire

[dv/tle_echo_checker.sv]
`timescale 1ns / 1ps
module tle_echo_checker #(
  parameter int unsigned LINE_LENGTH = tle_pkg::LINE_LENGTH_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [15:0] m_axis_tdata,
  input  wire logic        m_axis_tlast,
  output int               fail_count_o,
  output int               pending_o
);
  import tle_pkg::*;

  typedef struct packed {
    echo_action_e act;
    logic [7:0]   chr;
    logic         last;
  } echo_t;

  echo_t      pending_echoes[$];
  logic [7:0] line_text[64];
  logic [6:0] line_len;
  logic       session_over;
  int         fails = 0;

  task automatic predict_echoes(input logic [7:0] key);
    echo_t run_q[$];
    echo_t tail;
    if (session_over) begin
      return;
    end
    if (key == KEY_NL) begin
      run_q.push_back('{ACT_NEWLINE, 8'h00, 1'b0});
      line_len = '0;
    end else if (key == KEY_EOF) begin
      if (line_len == 0) begin
        run_q.push_back('{ACT_END, 8'h00, 1'b0});
        session_over = 1'b1;
      end
    end else if (key == KEY_KILL) begin
      run_q.push_back('{ACT_KILL, 8'h00, 1'b0});
      line_len = '0;
    end else if (key == KEY_BS || key == KEY_DEL) begin
      if (line_len != 0) begin
        line_len = line_len - 7'd1;
        run_q.push_back('{ACT_ERASE, 8'h00, 1'b0});
      end
    end else if (key == KEY_WERASE) begin
      while (line_len != 0 && line_text[(line_len - 7'd1) & 7'd63] == KEY_SPACE) begin
        line_len = line_len - 7'd1;
        run_q.push_back('{ACT_ERASE, 8'h00, 1'b0});
      end
      while (line_len != 0 && line_text[(line_len - 7'd1) & 7'd63] != KEY_SPACE) begin
        line_len = line_len - 7'd1;
        run_q.push_back('{ACT_ERASE, 8'h00, 1'b0});
      end
    end else if (key < KEY_SPACE || key > KEY_TILDE) begin
      run_q.push_back('{ACT_BEEP, 8'h00, 1'b0});
    end else begin
      if (line_len >= LINE_LENGTH - 1) begin
        line_len = '0;
        run_q.push_back('{ACT_NEWLINE, 8'h00, 1'b0});
      end
      line_text[line_len & 7'd63] = key;
      line_len = line_len + 7'd1;
      run_q.push_back('{ACT_CHAR, key, 1'b0});
    end
    if (run_q.size() != 0) begin
      tail = run_q.pop_back();
      tail.last = 1'b1;
      run_q.push_back(tail);
      foreach (run_q[i]) begin
        pending_echoes.push_back(run_q[i]);
      end
    end
  endtask

  always @(posedge clk_i) begin : watch
    echo_t seen;
    echo_t want;
    if (!rst_ni) begin
      pending_echoes.delete();
      line_len = '0;
      session_over = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_echoes(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.act = echo_action_e'(m_axis_tdata[2:0]);
        seen.chr = m_axis_tdata[10:3];
        seen.last = m_axis_tlast;
        if (pending_echoes.size() == 0) begin
          $error("Unexpected echo result: action %0d char %0d last %0d",
                 seen.act, seen.chr, seen.last);
          fails++;
        end else begin
          want = pending_echoes.pop_front();
          if (seen.act != want.act) begin
            $error("echo_action expected %0d actual %0d", want.act, seen.act);
            fails++;
          end
          if (seen.chr != want.chr) begin
            $error("echo_char expected %0d actual %0d", want.chr, seen.chr);
            fails++;
          end
          if (seen.last != want.last) begin
            $error("last_of_run expected %0d actual %0d", want.last, seen.last);
            fails++;
          end
        end
      end
    end
    pending_o <= pending_echoes.size();
    fail_count_o <= fails;
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import tle_pkg::*;

  localparam int unsigned LINE_LENGTH = LINE_LENGTH_DEFAULT;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_KEYS = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [15:0] m_axis_tdata;
  wire         m_axis_tlast;

  int         fail_count;
  int         pending;
  int         burst_left = 0;
  int         keys_sent = 0;
  int         quiet_cycles = 0;
  logic [1:0] rx_mode = 2'd0;
  int         rx_left = 0;

  always #10 clk_i = ~clk_i;

  terminal_line_editor_top #(
    .LINE_LENGTH(LINE_LENGTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  tle_echo_checker #(
    .LINE_LENGTH(LINE_LENGTH)
  ) echo_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= 2'($urandom_range(0, 3));
      rx_left <= $urandom_range(10, 150);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      2'd0: begin
        m_axis_tready <= 1'b1;
      end
      2'd1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      2'd2: begin
        m_axis_tready <= (rx_left % 16) < 9;
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $error("No request or result moved for %0d cycles", STALL_LIMIT);
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    return c;
  endfunction

  task automatic put_key(input logic [7:0] key);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= key;
    do @(posedge clk_i); while (!s_axis_tready);
    keys_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int   target;
    int   n;
    logic drained;
    logic [7:0] noise;
    drained = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Erase keys on an empty line give no result.
    put_key(KEY_BS);
    put_key(KEY_DEL);
    put_key(KEY_WERASE);
    put_key(8'd120);
    put_key(KEY_SPACE);
    put_key(8'd121);
    put_key(8'd122);
    put_key(KEY_SPACE);
    put_key(KEY_SPACE);
    // Trailing spaces go first, then the word.
    put_key(KEY_WERASE);
    put_key(KEY_EOF);
    put_key(8'd0);
    put_key(8'd31);
    put_key(8'd128);
    put_key(8'd255);
    put_key(KEY_TILDE);
    put_key(8'd33);
    put_key(KEY_BS);
    put_key(KEY_DEL);
    put_key(KEY_KILL);
    put_key(8'd113);
    put_key(KEY_NL);
    drain();

    target = keys_sent + RANDOM_KEYS;
    repeat (LINE_LENGTH - 1) put_key(word_char());
    put_key(KEY_WERASE);
    repeat (LINE_LENGTH) put_key(word_char());
    put_key(KEY_WERASE);

    while (keys_sent < target) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3: begin
          n = $urandom_range(1, 10);
          repeat (n) put_key(word_char());
          repeat ($urandom_range(1, 3)) put_key(KEY_SPACE);
        end
        4: begin
          repeat ($urandom_range(1, 3)) put_key(($urandom_range(0, 1) == 0) ? KEY_BS : KEY_DEL);
        end
        5: begin
          put_key(KEY_WERASE);
        end
        6: begin
          put_key(($urandom_range(0, 1) == 0) ? KEY_NL : KEY_KILL);
        end
        7: begin
          n = $urandom_range(50, 70);
          repeat (n) put_key(word_char());
          if ($urandom_range(0, 1) == 1) begin
            put_key(KEY_WERASE);
          end
        end
        8: begin
          noise = 8'($urandom_range(0, 255));
          if (noise == KEY_EOF) begin
            noise = KEY_NL;
          end
          put_key(noise);
        end
        9: begin
          put_key(word_char());
          put_key(KEY_EOF);
        end
        10: begin
          put_key(8'($urandom_range(32, 126)));
        end
        default: begin
          put_key(word_char());
          repeat ($urandom_range(1, 4)) put_key(KEY_SPACE);
          put_key(KEY_WERASE);
        end
      endcase
      if (!drained && keys_sent >= target - RANDOM_KEYS / 2) begin
        drain();
        drained = 1'b1;
      end
    end

    // End of session on an empty line; everything after it is ignored.
    put_key(KEY_NL);
    put_key(KEY_EOF);
    repeat (4) put_key(8'($urandom_range(0, 255)));
    put_key(KEY_NL);
    drain();
    repeat (LINE_LENGTH + 8) @(posedge clk_i);

    if (pending != 0) begin
      $error("%0d echo results never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/tle_pkg.sv
rtl/tle_ram.sv
rtl/tle_datapath.sv
rtl/tle_ctrl.sv
rtl/terminal_line_editor_top.sv
dv/tle_echo_checker.sv
dv/testbench.sv
